### rtl/tlvd_pkg.sv
// Package: shared types and constants of the TLV stream deframer.
`default_nettype none
package tlvd_pkg;

  // Number of big-endian length bytes after the type byte (1 to 4)
  localparam int LENGTH_BYTES = 4;
  localparam logic [1:0] LEN_LAST = 2'(LENGTH_BYTES - 1);

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_TYPE = 2'd0,
    ROLE_LEN  = 2'd1,
    ROLE_PAY  = 2'd2,
    ROLE_IGN  = 2'd3
  } role_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNC_HDR = 2'd1,
    ST_TRUNC_PAY = 2'd2,
    ST_BAD_LEN   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  byte_role;
    logic [7:0]  segment_type;
    logic        segment_start;
    logic        segment_end;
    logic [30:0] payload_length;
    logic [1:0]  status;
    logic        stream_done;
  } out_item_t;

  // Handoff from the input stage to the parser
  typedef struct packed {
    logic     valid;
    logic     advance;
    in_item_t item;
  } stage_ctl_t;

endpackage
`default_nettype wire

### rtl/tlvd_in_stage.sv
// Input register stage: holds one accepted word until the parser takes it.
`default_nettype none
module tlvd_in_stage
  import tlvd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     advance,
  output logic          stage_valid,
  output in_item_t      stage_item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  // Accept when empty or when the held word moves on this cycle
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_valid ? 1'b1 : (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule
`default_nettype wire

### rtl/tlvd_parser.sv
// Parser: segment state registers and the per-word decode.
`default_nettype none
module tlvd_parser
  import tlvd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire stage_ctl_t ctl,
  output out_item_t       result
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [30:0] remain_r, remain_nxt;
  logic [7:0]  type_r, type_nxt;
  status_t     err_r, err_nxt;

  logic [7:0]  b;
  logic        last;
  logic [31:0] accum_sh;
  logic [30:0] remain_dec;

  assign b          = ctl.item.data_byte;
  assign last       = ctl.item.stream_last;
  assign accum_sh   = {accum_r[23:0], b};
  assign remain_dec = remain_r - 31'd1;

  // Decode one word and work out the next state
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    accum_nxt  = accum_r;
    remain_nxt = remain_r;
    type_nxt   = type_r;
    err_nxt    = err_r;

    result                = '0;
    result.out_byte       = b;
    result.byte_role      = ROLE_IGN;
    result.status         = ST_OK;
    result.stream_done    = last;

    if (err_r != ST_OK) begin
      result.status = err_r;
    end else begin
      case (phase_r)
        PH_TYPE: begin
          type_nxt             = b;
          result.byte_role     = ROLE_TYPE;
          result.segment_type  = b;
          result.segment_start = 1'b1;
          cnt_nxt              = 2'd0;
          accum_nxt            = '0;
          phase_nxt            = PH_LEN;
          if (last) result.status = ST_TRUNC_HDR;
        end
        PH_LEN: begin
          result.byte_role    = ROLE_LEN;
          result.segment_type = type_r;
          accum_nxt           = accum_sh;
          if (cnt_r == LEN_LAST) begin
            cnt_nxt = 2'd0;
            if (accum_sh[31]) begin
              result.status = ST_BAD_LEN;
              err_nxt       = ST_BAD_LEN;
            end else if (accum_sh == 32'd0) begin
              result.segment_end = 1'b1;
              phase_nxt          = PH_TYPE;
            end else begin
              result.payload_length = accum_sh[30:0];
              remain_nxt            = accum_sh[30:0];
              phase_nxt             = PH_PAY;
              if (last) result.status = ST_TRUNC_PAY;
            end
          end else begin
            cnt_nxt = cnt_r + 2'd1;
            if (last) result.status = ST_TRUNC_HDR;
          end
        end
        PH_PAY: begin
          result.byte_role      = ROLE_PAY;
          result.segment_type   = type_r;
          result.payload_length = accum_r[30:0];
          remain_nxt            = remain_dec;
          if (remain_dec == 31'd0) begin
            result.segment_end = 1'b1;
            phase_nxt          = PH_TYPE;
          end else if (last) begin
            result.status = ST_TRUNC_PAY;
          end
        end
        default: begin
          phase_nxt = PH_TYPE;
        end
      endcase
    end

    // Drop all state at the end of the stream
    if (last) begin
      phase_nxt  = PH_TYPE;
      cnt_nxt    = 2'd0;
      accum_nxt  = '0;
      remain_nxt = '0;
      type_nxt   = '0;
      err_nxt    = ST_OK;
    end
  end

  // Advance state only when the word moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      cnt_r    <= 2'd0;
      accum_r  <= '0;
      remain_r <= '0;
      type_r   <= '0;
      err_r    <= ST_OK;
    end else if (ctl.valid && ctl.advance) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      accum_r  <= accum_nxt;
      remain_r <= remain_nxt;
      type_r   <= type_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/tlv_stream_deframer.sv
// Flow: an accepted word waits in the input register, then is decoded into the result register.
// Throughput: one word per cycle while out_ready is high; the input register and the result register
// let a new word enter while a finished result still waits on out_ready.
// Reset: synchronous active-low rst_n empties both registers and returns the
// parser to expecting a type byte with no error held.
`default_nettype none
module tlv_stream_deframer
  import tlvd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  logic       stage_valid;
  in_item_t   stage_item;
  logic       advance;
  stage_ctl_t ctl;
  out_item_t  result;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r;

  // Move the held word on when the result register is free or draining
  assign advance = stage_valid && (!out_valid_r || out_ready);

  tlvd_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  assign ctl.valid   = stage_valid;
  assign ctl.advance = advance;
  assign ctl.item    = stage_item;

  tlvd_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .result (result)
  );

  // Result register
  assign out_valid_nxt = advance ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire
